// ===== sv/pfe_pkg.sv =====
package pfe_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 12;

    // Depth of the queue between the accumulating front and the arithmetic back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;
    localparam int START_W    = 6;
    localparam int COUNT_W    = 7;

    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_START = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_COUNT = 4'd1;

    localparam logic [START_W-1:0] START_RST = 6'd0;
    localparam logic [COUNT_W-1:0] COUNT_RST = 7'd8;

    // Result field widths.
    localparam int BASE_Q8_W  = 20;
    localparam int PEAK_Q8_W  = 21;
    localparam int PEAK_IDX_W = 6;
    localparam int INTEG_Q8_W = 27;
    localparam int OUT_FIELDS_W = BASE_Q8_W + PEAK_Q8_W + PEAK_IDX_W + INTEG_Q8_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Widths that follow from the sample width and the waveform length.
    function automatic int in_data_w(input int sb);
        return ((sb + 7) / 8) * 8;
    endfunction

    function automatic int pos_w(input int ms);
        return $clog2(ms + 1);
    endfunction

    function automatic int idx_w(input int ms);
        return $clog2(ms);
    endfunction

    function automatic int bsum_w(input int sb);
        return sb + COUNT_W;
    endfunction

    function automatic int num_w(input int sb);
        return bsum_w(sb) + 8;
    endfunction

    function automatic int tsum_w(input int sb, input int ms);
        return sb + $clog2(ms) + 1;
    endfunction

    // Record handed from front to back: effective count, baseline sum, tail
    // maximum, its index, tail sum and tail count.
    function automatic int rec_w(input int sb, input int ms);
        return COUNT_W + bsum_w(sb) + sb + idx_w(ms) + tsum_w(sb, ms) + pos_w(ms);
    endfunction

endpackage

// ===== sv/pfe_front.sv =====
module pfe_front #(
    parameter int MAX_SAMPLES = pfe_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = pfe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   s_valid,
    output logic                                                   s_ready,
    input  logic signed [SAMPLE_BITS-1:0]                          s_sample,
    input  logic                                                   s_last,
    input  logic                                                   cfg_valid,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]                          cfg_index,
    input  logic [pfe_pkg::CFG_DATA_W-1:0]                         cfg_data,
    input  logic                                                   q_full,
    output logic                                                   q_push,
    output logic [pfe_pkg::rec_w(SAMPLE_BITS, MAX_SAMPLES)-1:0]    q_data
);

    localparam int POS_W  = pfe_pkg::pos_w(MAX_SAMPLES);
    localparam int IDX_W  = pfe_pkg::idx_w(MAX_SAMPLES);
    localparam int BSUM_W = pfe_pkg::bsum_w(SAMPLE_BITS);
    localparam int TSUM_W = pfe_pkg::tsum_w(SAMPLE_BITS, MAX_SAMPLES);
    localparam int END_W  = pfe_pkg::COUNT_W + 1;
    localparam int CMP_W  = ((POS_W > END_W) ? POS_W : END_W) + 1;

    logic [pfe_pkg::START_W-1:0] start_reg;
    logic [pfe_pkg::COUNT_W-1:0] count_reg;

    logic [POS_W-1:0]              pos_reg, pos_next, pos_upd;
    logic signed [BSUM_W-1:0]      bsum_reg, bsum_next, bsum_upd;
    logic signed [SAMPLE_BITS-1:0] maxs_reg, maxs_next, maxs_upd;
    logic [IDX_W-1:0]              maxpos_reg, maxpos_next, maxpos_upd;
    logic signed [TSUM_W-1:0]      tsum_reg, tsum_next, tsum_upd;
    logic [POS_W-1:0]              tcnt_reg, tcnt_next, tcnt_upd;

    logic [pfe_pkg::COUNT_W-1:0] count_eff;
    logic [END_W-1:0]            win_end;
    logic                        accept, in_range, in_base, in_tail;
    logic [SAMPLE_BITS-1:0]      most_neg;

    assign most_neg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;

    always_comb begin
        count_eff = (count_reg == '0) ? pfe_pkg::COUNT_W'(1) : count_reg;
        win_end   = END_W'(start_reg) + END_W'(count_eff);
        in_range  = pos_reg < POS_W'(MAX_SAMPLES);
        in_base   = in_range && (CMP_W'(pos_reg) >= CMP_W'(start_reg))
                    && (CMP_W'(pos_reg) < CMP_W'(win_end));
        in_tail   = in_range && (CMP_W'(pos_reg) >= CMP_W'(win_end));

        pos_upd    = pos_reg;
        bsum_upd   = bsum_reg;
        maxs_upd   = maxs_reg;
        maxpos_upd = maxpos_reg;
        tsum_upd   = tsum_reg;
        tcnt_upd   = tcnt_reg;

        if (accept) begin
            if (in_base) begin
                bsum_upd = bsum_reg + BSUM_W'(s_sample);
            end
            if (in_tail) begin
                // First tail sample always wins; afterwards only a strictly larger one.
                if ((tcnt_reg == '0) || (s_sample > maxs_reg)) begin
                    maxs_upd   = s_sample;
                    maxpos_upd = pos_reg[IDX_W-1:0];
                end
                tsum_upd = tsum_reg + TSUM_W'(s_sample);
                tcnt_upd = tcnt_reg + POS_W'(1);
            end
            if (in_range) begin
                pos_upd = pos_reg + POS_W'(1);
            end
        end

        q_push = accept && s_last;
        q_data = {count_eff, bsum_upd, maxs_upd, maxpos_upd, tsum_upd, tcnt_upd};

        if (q_push) begin
            pos_next    = '0;
            bsum_next   = '0;
            maxs_next   = $signed(most_neg);
            maxpos_next = '0;
            tsum_next   = '0;
            tcnt_next   = '0;
        end else begin
            pos_next    = pos_upd;
            bsum_next   = bsum_upd;
            maxs_next   = maxs_upd;
            maxpos_next = maxpos_upd;
            tsum_next   = tsum_upd;
            tcnt_next   = tcnt_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= pfe_pkg::START_RST;
            count_reg  <= pfe_pkg::COUNT_RST;
            pos_reg    <= '0;
            bsum_reg   <= '0;
            maxs_reg   <= $signed(most_neg);
            maxpos_reg <= '0;
            tsum_reg   <= '0;
            tcnt_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == pfe_pkg::REG_BASELINE_START) begin
                    start_reg <= cfg_data[pfe_pkg::START_W-1:0];
                end else if (cfg_index == pfe_pkg::REG_BASELINE_COUNT) begin
                    count_reg <= cfg_data[pfe_pkg::COUNT_W-1:0];
                end
            end
            pos_reg    <= pos_next;
            bsum_reg   <= bsum_next;
            maxs_reg   <= maxs_next;
            maxpos_reg <= maxpos_next;
            tsum_reg   <= tsum_next;
            tcnt_reg   <= tcnt_next;
        end
    end

endmodule

// ===== sv/pfe_queue.sv =====
module pfe_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pfe_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

// ===== sv/pfe_back.sv =====
module pfe_back #(
    parameter int MAX_SAMPLES = pfe_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = pfe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                q_empty,
    input  logic [pfe_pkg::rec_w(SAMPLE_BITS, MAX_SAMPLES)-1:0] q_data,
    output logic                                                q_pop,
    output logic                                                m_valid,
    input  logic                                                m_ready,
    output logic [pfe_pkg::BASE_Q8_W-1:0]                       m_baseline_q8,
    output logic [pfe_pkg::PEAK_Q8_W-1:0]                       m_peak_q8,
    output logic [pfe_pkg::PEAK_IDX_W-1:0]                      m_peak_index,
    output logic [pfe_pkg::INTEG_Q8_W-1:0]                      m_integral_q8,
    output logic                                                m_no_peak_window
);

    localparam int POS_W  = pfe_pkg::pos_w(MAX_SAMPLES);
    localparam int IDX_W  = pfe_pkg::idx_w(MAX_SAMPLES);
    localparam int BSUM_W = pfe_pkg::bsum_w(SAMPLE_BITS);
    localparam int NUM_W  = pfe_pkg::num_w(SAMPLE_BITS);
    localparam int TSUM_W = pfe_pkg::tsum_w(SAMPLE_BITS, MAX_SAMPLES);
    localparam int DV_W   = pfe_pkg::COUNT_W;
    localparam int BIT_W  = $clog2(NUM_W);
    localparam int PROD_W = POS_W + 1 + NUM_W;
    localparam int PEAK_W = NUM_W + 1;
    localparam int INT_W  = (((TSUM_W + 8) > PROD_W) ? (TSUM_W + 8) : PROD_W) + 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SIGN = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIN  = 5'b10000
    } back_state_t;

    back_state_t state_reg, state_next;

    // Fields of the record at the head of the queue.
    logic [DV_W-1:0]               in_count;
    logic signed [BSUM_W-1:0]      in_bsum;
    logic signed [SAMPLE_BITS-1:0] in_maxs;
    logic [IDX_W-1:0]              in_maxpos;
    logic signed [TSUM_W-1:0]      in_tsum;
    logic [POS_W-1:0]              in_tcnt;

    logic [NUM_W-1:0]              quo_reg, quo_next;
    logic [DV_W-1:0]               rem_reg, rem_next;
    logic [DV_W-1:0]               dvs_reg, dvs_next;
    logic                          neg_reg, neg_next;
    logic [BIT_W-1:0]              bit_cnt_reg, bit_cnt_next;
    logic signed [SAMPLE_BITS-1:0] maxs_reg, maxs_next;
    logic [IDX_W-1:0]              maxpos_reg, maxpos_next;
    logic signed [TSUM_W-1:0]      tsum_reg, tsum_next;
    logic [POS_W-1:0]              tcnt_reg, tcnt_next;
    logic signed [NUM_W-1:0]       base_reg, base_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;

    logic                                m_valid_reg, m_valid_next;
    logic [pfe_pkg::BASE_Q8_W-1:0]       out_base_reg, out_base_next;
    logic [pfe_pkg::PEAK_Q8_W-1:0]       out_peak_reg, out_peak_next;
    logic [pfe_pkg::PEAK_IDX_W-1:0]      out_idx_reg, out_idx_next;
    logic [pfe_pkg::INTEG_Q8_W-1:0]      out_int_reg, out_int_next;
    logic                                out_none_reg, out_none_next;

    logic signed [NUM_W-1:0]  num;
    logic [DV_W:0]            trial, diff;
    logic                     ge;
    logic signed [PEAK_W-1:0] peak_full;
    logic signed [INT_W-1:0]  integ_full;
    logic [IDX_W+pfe_pkg::PEAK_IDX_W-1:0] idx_ext;

    assign {in_count, in_bsum, in_maxs, in_maxpos, in_tsum, in_tcnt} = q_data;

    assign m_valid          = m_valid_reg;
    assign m_baseline_q8    = out_base_reg;
    assign m_peak_q8        = out_peak_reg;
    assign m_peak_index     = out_idx_reg;
    assign m_integral_q8    = out_int_reg;
    assign m_no_peak_window = out_none_reg;

    always_comb begin
        state_next    = state_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        neg_next      = neg_reg;
        bit_cnt_next  = bit_cnt_reg;
        maxs_next     = maxs_reg;
        maxpos_next   = maxpos_reg;
        tsum_next     = tsum_reg;
        tcnt_next     = tcnt_reg;
        base_next     = base_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_base_next = out_base_reg;
        out_peak_next = out_peak_reg;
        out_idx_next  = out_idx_reg;
        out_int_next  = out_int_reg;
        out_none_next = out_none_reg;
        q_pop         = 1'b0;

        // Scaled baseline sum; the divider works on its magnitude.
        num   = $signed({in_bsum, 8'b0});
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = trial >= {1'b0, dvs_reg};

        peak_full  = PEAK_W'($signed({maxs_reg, 8'b0})) - PEAK_W'(base_reg);
        integ_full = INT_W'($signed({tsum_reg, 8'b0})) - INT_W'(prod_reg);
        idx_ext    = {{pfe_pkg::PEAK_IDX_W{1'b0}}, maxpos_reg};

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop        = 1'b1;
                    neg_next     = in_bsum[BSUM_W-1];
                    quo_next     = in_bsum[BSUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                    rem_next     = '0;
                    dvs_next     = in_count;
                    bit_cnt_next = BIT_W'(NUM_W - 1);
                    maxs_next    = in_maxs;
                    maxpos_next  = in_maxpos;
                    tsum_next    = in_tsum;
                    tcnt_next    = in_tcnt;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle, restoring division.
                rem_next = ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], ge};
                if (bit_cnt_reg == '0) begin
                    state_next = ST_SIGN;
                end else begin
                    bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                end
            end
            ST_SIGN: begin
                base_next  = neg_reg ? $signed(NUM_W'(~quo_reg + 1'b1)) : $signed(quo_reg);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = PROD_W'($signed({1'b0, tcnt_reg})) * PROD_W'(base_reg);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    out_base_next = base_reg[pfe_pkg::BASE_Q8_W-1:0];
                    if (tcnt_reg == '0) begin
                        out_peak_next = '0;
                        out_idx_next  = '0;
                        out_int_next  = '0;
                        out_none_next = 1'b1;
                    end else begin
                        out_peak_next = peak_full[pfe_pkg::PEAK_Q8_W-1:0];
                        out_idx_next  = idx_ext[pfe_pkg::PEAK_IDX_W-1:0];
                        out_int_next  = integ_full[pfe_pkg::INTEG_Q8_W-1:0];
                        out_none_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        neg_reg      <= neg_next;
        bit_cnt_reg  <= bit_cnt_next;
        maxs_reg     <= maxs_next;
        maxpos_reg   <= maxpos_next;
        tsum_reg     <= tsum_next;
        tcnt_reg     <= tcnt_next;
        base_reg     <= base_next;
        prod_reg     <= prod_next;
        out_base_reg <= out_base_next;
        out_peak_reg <= out_peak_next;
        out_idx_reg  <= out_idx_next;
        out_int_reg  <= out_int_next;
        out_none_reg <= out_none_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (dvs_reg != '0))
        else $error("division started with a zero divisor");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the final state");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && bit_cnt_reg == '0) |=> (state_reg == ST_SIGN))
        else $error("divider did not finish after its last bit");

endmodule

// ===== sv/pulse_feature_extractor_unit.sv =====
// Pulse feature extractor. Waveform samples enter on the s_axis channel, one
// signed converter code per item, with tlast on the final sample. The cfg
// channel sets the baseline window: index 0 is the first baseline sample,
// index 1 the number of samples averaged (zero is taken as one); the user
// must write it only while no waveform is in flight, as the block does not
// enforce this, and cfg_ready is always high. One result item per waveform
// leaves on m_axis: baseline mean, peak above baseline, peak index and
// baseline-subtracted integral, all but the index in Q8, with tuser set
// when no sample followed the baseline window. Samples are accepted one per
// cycle while the queue has room. The last sample hands its sums to a
// two-entry queue; the back end then divides one quotient bit per cycle over
// the scaled baseline sum of NUM_W = SAMPLE_BITS + 15 bits. The back end
// takes no new record until it has finished the last one, so very short
// waveforms fill the queue and s_axis_tready drops until an entry frees up.
// The result sits in an output register; while m_axis_tready is low it holds
// and the front keeps taking samples until the queue fills. Reset clears the
// accumulators, queue and output valid, and restores the register defaults.
module pulse_feature_extractor_unit #(
    parameter int MAX_SAMPLES = pfe_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = pfe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // Sample stream.
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    input  logic [pfe_pkg::in_data_w(SAMPLE_BITS)-1:0]   s_axis_tdata,  // sample
    input  logic                                         s_axis_tlast,
    // Configuration writes.
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]                cfg_index,
    input  logic [pfe_pkg::CFG_DATA_W-1:0]               cfg_data,
    // Result stream.
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // baseline_q8, peak_q8, peak_index, integral_q8, zero padding
    output logic [pfe_pkg::OUT_DATA_W-1:0]               m_axis_tdata,
    output logic [0:0]                                   m_axis_tuser   // no_peak_window
);

    localparam int REC_W = pfe_pkg::rec_w(SAMPLE_BITS, MAX_SAMPLES);

    logic             q_push, q_pop, q_full, q_empty;
    logic [REC_W-1:0] q_wdata, q_rdata;

    logic [pfe_pkg::BASE_Q8_W-1:0]  baseline_q8;
    logic [pfe_pkg::PEAK_Q8_W-1:0]  peak_q8;
    logic [pfe_pkg::PEAK_IDX_W-1:0] peak_index;
    logic [pfe_pkg::INTEG_Q8_W-1:0] integral_q8;
    logic                           no_peak_window;

    assign cfg_ready = 1'b1;

    // Front end: position tracking, window decode and accumulation.
    pfe_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_sample  ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
        .s_last    (s_axis_tlast),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // Per-waveform records waiting for the arithmetic.
    pfe_queue #(
        .WIDTH (REC_W),
        .DEPTH (pfe_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // Back end: baseline division, multiply and final subtraction.
    pfe_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_data           (q_rdata),
        .q_pop            (q_pop),
        .m_valid          (m_axis_tvalid),
        .m_ready          (m_axis_tready),
        .m_baseline_q8    (baseline_q8),
        .m_peak_q8        (peak_q8),
        .m_peak_index     (peak_index),
        .m_integral_q8    (integral_q8),
        .m_no_peak_window (no_peak_window)
    );

    assign m_axis_tdata = {{(pfe_pkg::OUT_DATA_W - pfe_pkg::OUT_FIELDS_W){1'b0}},
                           integral_q8, peak_index, peak_q8, baseline_q8};
    assign m_axis_tuser = no_peak_window;

endmodule

// ===== tb/pulse_feature_checker.sv =====
`timescale 1ns / 100ps

// Watches the configuration, sample and result channels of the pulse feature
// extractor. It keeps its own copy of the window registers and of the waveform
// accumulators, works out the features of every closed waveform and compares
// each result item, field by field, with the oldest feature set still owed.
module pulse_feature_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [pfe_pkg::in_data_w(pfe_pkg::SAMPLE_BITS_DEF)-1:0] s_axis_tdata,
    input  logic                               s_axis_tlast,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [pfe_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic [0:0]                         m_axis_tuser,
    output int                                 error_count,
    output int                                 pending_results
);
    import pfe_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;

    typedef struct {
        logic [BASE_Q8_W-1:0]  baseline_q8;
        logic [PEAK_Q8_W-1:0]  peak_q8;
        logic [PEAK_IDX_W-1:0] peak_index;
        logic [INTEG_Q8_W-1:0] integral_q8;
        logic                  no_peak_window;
    } features_t;

    features_t expected_features[$];

    logic [START_W-1:0] win_start;
    logic [COUNT_W-1:0] win_count;

    int unsigned position;
    int unsigned tail_len;
    int unsigned peak_pos;
    longint      baseline_sum;
    longint      tail_sum;
    longint      peak_sample;
    int          errors = 0;

    task automatic clear_waveform();
        position     = 0;
        baseline_sum = 0;
        peak_sample  = -(longint'(1) << (SB - 1));
        peak_pos     = 0;
        tail_sum     = 0;
        tail_len     = 0;
    endtask

    // Accumulates one sample; the last one of a waveform owes a feature set.
    task automatic take_sample(input logic signed [SB-1:0] s, input logic closes);
        int unsigned eff_count;
        int unsigned win_end;
        longint      base;
        longint      peak;
        longint      integ;
        features_t   f;
        eff_count = (win_count == 0) ? 1 : win_count;
        win_end   = win_start + eff_count;
        if (position < MAX_SAMPLES_DEF) begin
            if (position >= win_start && position < win_end) begin
                baseline_sum += s;
            end else if (position >= win_end) begin
                if (tail_len == 0 || s > peak_sample) begin
                    peak_sample = s;
                    peak_pos    = position;
                end
                tail_sum += s;
                tail_len++;
            end
            position++;
        end
        if (closes) begin
            base  = (baseline_sum * 256) / longint'(eff_count);
            peak  = 0;
            integ = 0;
            f.peak_index     = '0;
            f.no_peak_window = (tail_len == 0);
            if (tail_len != 0) begin
                peak  = peak_sample * 256 - base;
                integ = tail_sum * 256 - longint'(tail_len) * base;
                f.peak_index = peak_pos[PEAK_IDX_W-1:0];
            end
            f.baseline_q8 = base[BASE_Q8_W-1:0];
            f.peak_q8     = peak[PEAK_Q8_W-1:0];
            f.integral_q8 = integ[INTEG_Q8_W-1:0];
            expected_features = {expected_features, f};
            clear_waveform();
        end
    endtask

    task automatic compare_field(input string label, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        features_t got;
        features_t want;
        if (!aresetn) begin
            win_start = START_RST;
            win_count = COUNT_RST;
            clear_waveform();
            expected_features.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BASELINE_START: win_start = cfg_data[START_W-1:0];
                    REG_BASELINE_COUNT: win_count = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_sample(s_axis_tdata[SB-1:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.baseline_q8    = m_axis_tdata[BASE_Q8_W-1:0];
                got.peak_q8        = m_axis_tdata[BASE_Q8_W +: PEAK_Q8_W];
                got.peak_index     = m_axis_tdata[BASE_Q8_W + PEAK_Q8_W +: PEAK_IDX_W];
                got.integral_q8    =
                    m_axis_tdata[BASE_Q8_W + PEAK_Q8_W + PEAK_IDX_W +: INTEG_Q8_W];
                got.no_peak_window = m_axis_tuser[0];
                if (expected_features.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, got %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = expected_features.pop_front();
                    compare_field("baseline_q8", want.baseline_q8, got.baseline_q8);
                    compare_field("peak_q8", want.peak_q8, got.peak_q8);
                    compare_field("peak_index", want.peak_index, got.peak_index);
                    compare_field("integral_q8", want.integral_q8, got.integral_q8);
                    compare_field("no_peak_window", want.no_peak_window,
                                  got.no_peak_window);
                end
            end
        end
        error_count     <= errors;
        pending_results <= expected_features.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the pulse feature extractor. The checker beside the
// block does all prediction and comparison; this module only feeds waveforms,
// drives the receiver, sets the window between phases and decides the outcome.
module tb_top;
    import pfe_pkg::*;

    localparam int PERIOD       = 12;
    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int IN_W         = in_data_w(SAMPLE_BITS_DEF);
    // Twice the back end's work on one waveform: a comfortable margin before
    // touching the registers or ending the run.
    localparam int SETTLE       = 2 * (SB + 19);
    localparam int RX_HOLD      = 400;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 150;
    localparam int SQUEEZE_ITEMS = 100;
    localparam int END_LIMIT    = 20000;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int LAST_IDX     = (1 << CFG_IDX_W) - 1;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;     // sample, zero padding
    logic                  s_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;     // baseline_q8, peak_q8, peak_index, integral_q8
    logic [0:0]            m_axis_tuser;     // no_peak_window

    int error_count;
    int pending_results;

    // Our own note of the window, used only to aim waveform lengths at its end.
    int unsigned win_start_now = START_RST;
    int unsigned win_count_now = COUNT_RST;

    // Set by the stimulus to ask the receiver for one long hold-off.
    bit rx_hold_request = 0;
    // While set the sender offers items back to back.
    bit tx_no_gaps = 0;
    int tx_style;
    int tx_left = 0;

    pulse_feature_extractor_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pulse_feature_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #(PERIOD / 2) aclk = ~aclk;
    end

    // Safety net: even the slowest correct run finishes well inside this.
    initial begin
        #(TIMEOUT_NS);
        $display("pulse_feature_extractor_unit test failed");
        $finish;
    end

    // Idle styles: 0 never waits, 1 draws a random wait, possibly none, on every
    // item, and 2 waits only now and then, so that long unbroken bursts also occur.
    function automatic int draw_gap(input int style);
        if (style == 0)
            return 0;
        if (style == 1)
            return $urandom_range(0, 13);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
    endfunction

    // Saturates a computed level into the converter's code range.
    function automatic logic signed [SB-1:0] to_code(input int x);
        if (x > (1 << (SB - 1)) - 1)
            return SB'((1 << (SB - 1)) - 1);
        if (x < -(1 << (SB - 1)))
            return SB'(-(1 << (SB - 1)));
        return SB'(x);
    endfunction

    // Result receiver. Each item it draws a stall before raising tready; once
    // in the run it is asked to hold off for a long stretch instead, so that
    // the queue behind the accumulators fills and the sample input backs up.
    initial begin
        int gap;
        int style;
        int left;
        m_axis_tready <= 1'b0;
        left = 0;
        style = 0;
        @(posedge aclk);
        forever begin
            if (rx_hold_request) begin
                rx_hold_request = 0;
                gap = RX_HOLD;
            end else begin
                if (left == 0) begin
                    style = $urandom_range(0, 2);
                    left  = $urandom_range(5, 30);
                end
                left--;
                gap = draw_gap(style);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Offers one sample item and returns once it has been taken. Valid is only
    // lowered when a gap is drawn, so back-to-back items keep it high.
    task automatic send_sample(input logic signed [SB-1:0] value, input logic closes);
        int gap;
        if (tx_left == 0) begin
            tx_style = $urandom_range(0, 2);
            tx_left  = $urandom_range(5, 40);
        end
        tx_left--;
        gap = tx_no_gaps ? 0 : draw_gap(tx_style);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - SB){1'b0}}, value};
        s_axis_tlast  <= closes;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Stops offering samples and waits for every owed result to come out. The
    // first edge lets the checker's count catch up with the last item.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    // Sets the baseline window while the block is idle. Now and then a write
    // to an index beyond the register list is thrown in, which must be ignored.
    task automatic set_window(input logic [CFG_DATA_W-1:0] start_value,
                              input logic [CFG_DATA_W-1:0] count_value);
        wait_for_results();
        repeat (SETTLE) @(posedge aclk);
        write_reg(REG_BASELINE_START, start_value);
        write_reg(REG_BASELINE_COUNT, count_value);
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_IDX_W'($urandom_range(32'(REG_BASELINE_COUNT) + 1, LAST_IDX)),
                      CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
        cfg_valid <= 1'b0;
        win_start_now = 32'(start_value[START_W-1:0]);
        win_count_now = 32'(count_value);
    endtask

    // One waveform of the given length. The shape is drawn per waveform:
    // uniform codes, quiet noise around a level, a pulse on a pedestal, rail
    // to rail codes, or values that tie often so the first maximum matters.
    task automatic send_waveform(input int len);
        int shape;
        int level;
        int amp;
        int peak_at;
        logic signed [SB-1:0] v;
        shape   = $urandom_range(0, 5);
        level   = $urandom_range(0, (1 << SB) - 1) - (1 << (SB - 1));
        amp     = $urandom_range(0, 3000);
        peak_at = $urandom_range(0, len);
        for (int i = 0; i < len; i++) begin
            case (shape)
                0: v = SB'($urandom_range(0, (1 << SB) - 1));
                1: v = to_code(level + $urandom_range(0, 16) - 8);
                2: v = to_code(level / 2 - 1024 + $urandom_range(0, 6) - 3 +
                               ((i >= peak_at && i < peak_at + 4) ? amp : 0));
                3: v = ($urandom_range(0, 1) == 1) ? to_code(1 << SB) : to_code(-(1 << SB));
                4: v = to_code(level + $urandom_range(0, 1));
                default: v = to_code(level);
            endcase
            send_sample(v, i == len - 1);
        end
    endtask

    // A run of random waveforms worth about `budget` sample items. Most
    // lengths are spread over the whole record; some land right on the end of
    // the baseline window, some are tiny and some run past the record length.
    // In squeeze mode every waveform is one or two samples long, which keeps
    // the slow back end permanently behind.
    task automatic run_phase(input int budget, input bit squeeze);
        int sent;
        int len;
        int pick;
        int win_end;
        sent = 0;
        while (sent < budget) begin
            win_end = win_start_now + ((win_count_now == 0) ? 1 : win_count_now);
            pick    = $urandom_range(0, 99);
            if (squeeze || pick < 8)
                len = $urandom_range(1, squeeze ? 2 : 3);
            else if (pick < 78)
                len = $urandom_range(1, MAX_SAMPLES_DEF);
            else if (pick < 92)
                len = (win_end + $urandom_range(0, 2) > 1) ? win_end + $urandom_range(0, 2) - 1
                                                           : 1;
            else
                len = $urandom_range(MAX_SAMPLES_DEF + 1, MAX_SAMPLES_DEF + 24);
            send_waveform(len);
            sent += len;
            // Occasionally the sender goes quiet until every result is out.
            if (!squeeze && $urandom_range(0, 29) == 0)
                wait_for_results();
        end
    endtask

    initial begin
        int shape_b[12];
        int shape_c[10];
        int wait_cycles;

        shape_b = '{-2048, -1, 1, 2047, -2048, 0, -5, 3, 2047, -2048, 2047, 0};
        shape_c = '{1, 1, 1, 1, 1, 1, 1, 1, -2048, -2048};

        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_BASELINE_START;
        cfg_data      <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset window (first eight samples).
        // A single sample: it falls inside the window, so the tail is empty.
        send_sample(SB'(2047), 1'b1);
        // Rail codes in the window, then a tail whose maximum ties: the first
        // of the two equal peaks must be reported.
        foreach (shape_b[i])
            send_sample(SB'(shape_b[i]), i == 11);
        // A tail made only of the most negative code, equal to the start value
        // of the running maximum; the first tail sample must still be taken.
        foreach (shape_c[i])
            send_sample(SB'(shape_c[i]), i == 9);

        // Random phases. The first few use the extreme windows: one sample,
        // start at the last sample of the record (with a start value whose top bit
        // falls outside the register), a zero count taken as one, a window
        // covering the whole record, the largest count, and an odd count so
        // the division truncates.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: set_window(7'd0, 7'd1);
                1: set_window(7'h7F, 7'd64);
                2: set_window(7'd0, 7'd0);
                3: set_window(7'd0, 7'd64);
                4: set_window(7'd40, 7'd127);
                5: set_window(7'd3, 7'd7);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        set_window(CFG_DATA_W'($urandom_range(0, 127)),
                                   CFG_DATA_W'($urandom_range(0, 127)));
                    else
                        set_window(CFG_DATA_W'($urandom_range(0, 15)),
                                   CFG_DATA_W'($urandom_range(1, 16)));
                end
            endcase
            run_phase(PHASE_ITEMS, 1'b0);

            // Once, right after the odd-count phase, the receiver holds off
            // while tiny waveforms stream in without gaps.
            if (p == 5) begin
                wait_for_results();
                rx_hold_request = 1;
                tx_no_gaps      = 1;
                run_phase(SQUEEZE_ITEMS, 1'b1);
                tx_no_gaps      = 0;
            end
        end

        // Drain: wait for every owed result, bounded, then let the back end
        // settle so that any stray extra result would still be seen.
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait_cycles = 0;
        while (pending_results != 0 && wait_cycles < END_LIMIT) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (SETTLE) @(posedge aclk);

        if (error_count == 0 && pending_results == 0)
            $display("pulse_feature_extractor_unit test passed");
        else
            $display("pulse_feature_extractor_unit test failed");
        $finish;
    end

endmodule
